/* hdl/grid_box_downsample_3d_assert.svh */
// Assertion macros for the grid box downsampler.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef GRID_BOX_DOWNSAMPLE_3D_ASSERT_SVH
`define GRID_BOX_DOWNSAMPLE_3D_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gbd_pkg.sv */
// Shared types and constants of the grid box downsampler.
// No dependencies.
package gbd_pkg;

    localparam int MAX_GRID        = 256;
    localparam int GRID_BITS       = 8;
    localparam int SAMPLE_BITS     = 24;
    localparam int MAX_FACTOR_LOG2 = 4;
    localparam int SUM_BITS        = SAMPLE_BITS + 3 * MAX_FACTOR_LOG2;
    localparam int STORE_DEPTH     = (MAX_GRID / 2) * (MAX_GRID / 2);
    localparam int IDX_BITS        = $clog2(STORE_DEPTH);
    localparam int GLOG_BITS       = 4;
    localparam int FLOG_BITS       = 3;
    localparam int CFG_DATA_BITS   = 4;

    localparam logic [GLOG_BITS-1:0] GRID_LOG2_RESET   = GLOG_BITS'(8);
    localparam logic [FLOG_BITS-1:0] FACTOR_LOG2_RESET = FLOG_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [GRID_BITS-1:0]          t_coord;
    typedef logic [IDX_BITS-1:0]           t_idx;

    typedef enum logic [0:0] {
        CFG_GRID_LOG2   = 1'b0,
        CFG_FACTOR_LOG2 = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic en;
        t_idx idx;
    } t_rd_req;

    typedef struct packed {
        logic    upd;
        logic    first;
        logic    bypass;
        t_sample sample;
        t_idx    idx;
    } t_rmw_req;

endpackage

/* hdl/gbd_in_if.sv */
// Input channel of the grid box downsampler: one fine sample per word.
// Depends on gbd_pkg.
interface gbd_in_if;
    import gbd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    frame_start;

    modport source(output valid, output sample, output frame_start, input ready);
    modport sink(input valid, input sample, input frame_start, output ready);
endinterface

/* hdl/gbd_out_if.sv */
// Output channel of the grid box downsampler: one coarse cell per word.
// Depends on gbd_pkg.
interface gbd_out_if;
    import gbd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample average;
    t_coord  coarse_x;
    t_coord  coarse_y;
    t_coord  coarse_z;
    logic    last_cell;

    modport source(output valid, output average, output coarse_x, output coarse_y,
                   output coarse_z, output last_cell, input ready);
    modport sink(input valid, input average, input coarse_x, input coarse_y,
                 input coarse_z, input last_cell, output ready);
endinterface

/* hdl/gbd_accum.sv */
// Coarse accumulator plane: one-port-read, one-port-write memory with
// read-modify-write and forwarding of the last write. Depends on gbd_pkg.
module gbd_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbd_pkg::t_rd_req  i_rd,
    input  gbd_pkg::t_rmw_req i_rmw,
    output gbd_pkg::t_sum     o_sum
);
    import gbd_pkg::*;

    logic [SUM_BITS-1:0] r_mem [STORE_DEPTH];
    logic [SUM_BITS-1:0] r_rd_data;
    logic [SUM_BITS-1:0] r_fwd_sum;
    t_idx                r_fwd_idx;
    logic                r_fwd_valid;

    logic [SUM_BITS-1:0] base;
    logic [SUM_BITS-1:0] samp_ext;
    logic [SUM_BITS-1:0] sum;
    logic                wr_en;

    always_comb begin
        samp_ext = {{(SUM_BITS - SAMPLE_BITS){i_rmw.sample[SAMPLE_BITS-1]}}, i_rmw.sample};
        base     = (r_fwd_valid && (r_fwd_idx == i_rmw.idx)) ? r_fwd_sum : r_rd_data;
        sum      = (i_rmw.first || i_rmw.bypass) ? samp_ext : base + samp_ext;
        wr_en    = i_rmw.upd && !i_rmw.bypass;
    end

    assign o_sum = t_sum'(sum);

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
        if (wr_en) begin
            r_mem[i_rmw.idx] <= sum;
        end
    end

    // Hold the last write so a read issued in the same cycle sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fwd_idx <= i_rmw.idx;
            r_fwd_sum <= sum;
        end
    end
endmodule

/* hdl/grid_box_downsample_3d.sv */
// Path: stage one registers a block's last fine sample, stage two its sum and stage three
// its average on o_avg_ch. Throughput: one sample per cycle unless back-pressure stalls, set
// by the forwarded accumulator read-modify-write: read at accept, add and write at s1_adv.
// Reset: synchronous, active low; clears position counters and pipeline valids and loads
// grid_log2 = 8, factor_log2 = 1. The accumulator memory is not cleared: the first sample
// of each block overwrites its entry. Depends on gbd_pkg, gbd_in_if, gbd_out_if, gbd_accum.
`include "grid_box_downsample_3d_assert.svh"

module grid_box_downsample_3d (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    gbd_in_if.sink                              i_sample_ch,
    gbd_out_if.source                           o_avg_ch,
    input  logic                                i_cfg_we,
    input  gbd_pkg::t_cfg_index                 i_cfg_index,
    input  logic [gbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import gbd_pkg::*;

    localparam logic signed [SUM_BITS:0] AVG_MAX = (SUM_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS:0] AVG_MIN = -((SUM_BITS + 1)'(1 << (SAMPLE_BITS - 1)));

    logic [GLOG_BITS-1:0] r_grid_log2;
    logic [FLOG_BITS-1:0] r_factor_log2;
    t_coord               r_plane;
    t_coord               r_row;
    t_coord               r_col;

    logic [GLOG_BITS-1:0] g_eff;
    logic [FLOG_BITS-1:0] f_eff;
    logic [GRID_BITS:0]   n_full;
    logic [GRID_BITS:0]   b_full;
    t_coord               nm;
    t_coord               bm;
    t_coord               p0;
    t_coord               r0;
    t_coord               c0;
    logic                 first0;
    logic                 last0;
    logic                 lastcell0;
    logic [GLOG_BITS-1:0] gf;
    logic [2*GRID_BITS-1:0] idx_wide;
    t_idx                 idx0;
    t_coord               n_plane;
    t_coord               n_row;
    t_coord               n_col;
    logic                 accept;

    logic                 r_s1_valid;
    t_sample              r_s1_sample;
    t_idx                 r_s1_idx;
    logic                 r_s1_first;
    logic                 r_s1_last;
    logic                 r_s1_lastcell;
    logic [FLOG_BITS-1:0] r_s1_f;
    t_coord               r_s1_x;
    t_coord               r_s1_y;
    t_coord               r_s1_z;
    logic                 s1_adv;

    logic                 r_s2_valid;
    t_sum                 r_s2_sum;
    logic [FLOG_BITS-1:0] r_s2_f;
    t_coord               r_s2_x;
    t_coord               r_s2_y;
    t_coord               r_s2_z;
    logic                 r_s2_lastcell;
    logic                 s2_ready;

    logic                 r_s3_valid;
    t_sample              r_s3_avg;
    t_coord               r_s3_x;
    t_coord               r_s3_y;
    t_coord               r_s3_z;
    logic                 r_s3_lastcell;
    logic                 s3_ready;

    t_rd_req              rd_req;
    t_rmw_req             rmw_req;
    t_sum                 s1_sum;

    logic [GLOG_BITS-1:0]  k;
    logic signed [SUM_BITS:0] sum_ext;
    logic [SUM_BITS:0]     half;
    logic signed [SUM_BITS:0] rnd;
    t_sample               avg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_log2   <= GRID_LOG2_RESET;
            r_factor_log2 <= FACTOR_LOG2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_LOG2:   r_grid_log2   <= i_cfg_data[GLOG_BITS-1:0];
                CFG_FACTOR_LOG2: r_factor_log2 <= i_cfg_data[FLOG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position, block flags and accumulator address of the incoming sample.
    always_comb begin
        if (r_grid_log2 < GLOG_BITS'(1)) begin
            g_eff = GLOG_BITS'(1);
        end else if (r_grid_log2 > GLOG_BITS'(GRID_BITS)) begin
            g_eff = GLOG_BITS'(GRID_BITS);
        end else begin
            g_eff = r_grid_log2;
        end

        f_eff = r_factor_log2;
        if (f_eff > FLOG_BITS'(MAX_FACTOR_LOG2)) begin
            f_eff = FLOG_BITS'(MAX_FACTOR_LOG2);
        end
        if ({1'b0, f_eff} > g_eff) begin
            f_eff = g_eff[FLOG_BITS-1:0];
        end

        n_full = (GRID_BITS + 1)'(1) << g_eff;
        b_full = (GRID_BITS + 1)'(1) << f_eff;
        nm     = GRID_BITS'(n_full - (GRID_BITS + 1)'(1));
        bm     = GRID_BITS'(b_full - (GRID_BITS + 1)'(1));

        p0 = (i_sample_ch.frame_start ? '0 : r_plane) & nm;
        r0 = (i_sample_ch.frame_start ? '0 : r_row) & nm;
        c0 = (i_sample_ch.frame_start ? '0 : r_col) & nm;

        first0    = ((p0 & bm) == '0) && ((r0 & bm) == '0) && ((c0 & bm) == '0);
        last0     = ((p0 & bm) == bm) && ((r0 & bm) == bm) && ((c0 & bm) == bm);
        lastcell0 = (p0 == nm) && (r0 == nm) && (c0 == nm);

        gf       = g_eff - {1'b0, f_eff};
        idx_wide = ({{GRID_BITS{1'b0}}, r0 >> f_eff} << gf) | {{GRID_BITS{1'b0}}, c0 >> f_eff};
        idx0     = idx_wide[IDX_BITS-1:0];

        n_col   = c0;
        n_row   = r0;
        n_plane = p0;
        if (c0 == nm) begin
            n_col = '0;
            if (r0 == nm) begin
                n_row = '0;
                n_plane = (p0 == nm) ? '0 : p0 + GRID_BITS'(1);
            end else begin
                n_row = r0 + GRID_BITS'(1);
            end
        end else begin
            n_col = c0 + GRID_BITS'(1);
        end
    end

    // Pipeline handshake.
    assign s3_ready          = !r_s3_valid || o_avg_ch.ready;
    assign s2_ready          = !r_s2_valid || s3_ready;
    assign s1_adv            = r_s1_valid && (!r_s1_last || s2_ready);
    assign i_sample_ch.ready = !r_s1_valid || s1_adv;
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane    <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_plane <= n_plane;
                r_row   <= n_row;
                r_col   <= n_col;
            end
            if (i_sample_ch.ready) begin
                r_s1_valid <= accept;
            end
            if (s2_ready) begin
                r_s2_valid <= s1_adv && r_s1_last;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample   <= i_sample_ch.sample;
            r_s1_idx      <= idx0;
            r_s1_first    <= first0;
            r_s1_last     <= last0;
            r_s1_lastcell <= lastcell0;
            r_s1_f        <= f_eff;
            r_s1_x        <= p0 >> f_eff;
            r_s1_y        <= r0 >> f_eff;
            r_s1_z        <= c0 >> f_eff;
        end
        if (s2_ready && s1_adv && r_s1_last) begin
            r_s2_sum      <= s1_sum;
            r_s2_f        <= r_s1_f;
            r_s2_x        <= r_s1_x;
            r_s2_y        <= r_s1_y;
            r_s2_z        <= r_s1_z;
            r_s2_lastcell <= r_s1_lastcell;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_avg      <= avg;
            r_s3_x        <= r_s2_x;
            r_s3_y        <= r_s2_y;
            r_s3_z        <= r_s2_z;
            r_s3_lastcell <= r_s2_lastcell;
        end
    end

    // Accumulator read at accept, add and write back as the sample leaves stage one.
    always_comb begin
        rd_req.en      = accept;
        rd_req.idx     = idx0;
        rmw_req.upd    = s1_adv;
        rmw_req.first  = r_s1_first;
        rmw_req.bypass = (r_s1_f == '0);
        rmw_req.sample = r_s1_sample;
        rmw_req.idx    = r_s1_idx;
    end

    gbd_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_req),
        .i_rmw   (rmw_req),
        .o_sum   (s1_sum)
    );

    // Divide by factor cubed: round half up, then saturate.
    always_comb begin
        k       = {r_s2_f, 1'b0} + {1'b0, r_s2_f};
        sum_ext = {r_s2_sum[SUM_BITS-1], r_s2_sum};
        half    = ((SUM_BITS + 1)'(1) << k) >> 1;
        rnd     = (sum_ext + signed'(half)) >>> k;
        if (rnd > AVG_MAX) begin
            avg = t_sample'(AVG_MAX[SAMPLE_BITS-1:0]);
        end else if (rnd < AVG_MIN) begin
            avg = t_sample'(AVG_MIN[SAMPLE_BITS-1:0]);
        end else begin
            avg = t_sample'(rnd[SAMPLE_BITS-1:0]);
        end
    end

    assign o_avg_ch.valid     = r_s3_valid;
    assign o_avg_ch.average   = r_s3_avg;
    assign o_avg_ch.coarse_x  = r_s3_x;
    assign o_avg_ch.coarse_y  = r_s3_y;
    assign o_avg_ch.coarse_z  = r_s3_z;
    assign o_avg_ch.last_cell = r_s3_lastcell;

    `GBD_ASSERT_NEXT(a_frame_restart, accept && i_sample_ch.frame_start, (r_col == GRID_BITS'(1)) && (r_row == '0) && (r_plane == '0), "frame start did not restart counters")
    `GBD_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_idx) && $stable(r_s1_sample), "stalled stage one word changed")
    `GBD_ASSERT_NOW(a_last_diag, r_s3_valid && r_s3_lastcell, (r_s3_x == r_s3_y) && (r_s3_y == r_s3_z), "last cell off the diagonal")
endmodule
